### src/csfm_pkg.sv
// csfm_pkg: shared types and constants for the camera stream fault monitor.
// No dependencies; used by every module under src.
package csfm_pkg;

  localparam int CHANNELS  = 4;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SHOWN_CH  = (CHANNELS < 4) ? CHANNELS : 4;

  // Fault codes
  localparam logic [1:0] FC_NONE        = 2'd0;
  localparam logic [1:0] FC_INTERRUPTED = 2'd1;
  localparam logic [1:0] FC_LOW_RATE    = 2'd2;

  // Operation codes on the input beat
  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_CHECK = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_STOP  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_WINDOW   = 2'd1;
  localparam logic [1:0] REG_MIN_FRMS = 2'd2;

  localparam logic [15:0] TIMEOUT_RST  = 16'd2000;
  localparam logic [15:0] WINDOW_RST   = 16'd1000;
  localparam logic [15:0] MIN_FRMS_RST = 16'd10;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  channel;
    logic [31:0] time_ms;
  } in_t;

  typedef struct packed {
    logic [7:0] fault_codes;
    logic       changed;
  } out_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic [1:0]          kind;
    logic                ch_ok;
    logic [CH_IDX_W-1:0] ch;
    logic [31:0]         time_ms;
  } cmd_t;

endpackage

### src/csfm_front.sv
// csfm_front: accepts event beats, classifies them and queues them for the back end.
// Depends on csfm_pkg.
module csfm_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  csfm_pkg::in_t in_data,
  output logic          cmd_valid,
  output csfm_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import csfm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  cmd_t             cls;

  // classify: a frame on a channel beyond the channel count is flagged here
  always_comb begin
    cls.kind    = in_data.operation;
    cls.ch_ok   = (32'(in_data.channel) < CHANNELS);
    cls.ch      = CH_IDX_W'(in_data.channel);
    cls.time_ms = in_data.time_ms;
  end

  assign busy      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (cmd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !cmd_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && cmd_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### src/csfm_back.sv
// csfm_back: holds monitor and per-channel state, executes queued commands.
// Checks visit one channel per cycle. Depends on csfm_pkg.
module csfm_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  csfm_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  output logic           out_strobe,
  output csfm_pkg::out_t out_data
);
  import csfm_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_CHECK = 1'b1;

  logic [15:0] timeout_r, window_r, min_frms_r;

  logic        state_r, state_nxt;
  logic [CH_IDX_W-1:0] cnt_r, cnt_nxt;
  logic        acc_r, acc_nxt;
  logic [31:0] now_r, now_nxt;
  logic [31:0] since_start_r, since_start_nxt;
  logic        strobe_r, strobe_nxt;
  logic        chg_r, chg_nxt;

  logic        active_r, active_nxt;
  logic [31:0] mon_since_r, mon_since_nxt;
  logic [1:0]  fcode_r [CHANNELS];
  logic [1:0]  fcode_nxt [CHANNELS];
  logic        has_frm_r [CHANNELS];
  logic        has_frm_nxt [CHANNELS];
  logic [31:0] last_r [CHANNELS];
  logic [31:0] last_nxt [CHANNELS];
  logic [31:0] wstart_r [CHANNELS];
  logic [31:0] wstart_nxt [CHANNELS];
  logic [15:0] fcount_r [CHANNELS];
  logic [15:0] fcount_nxt [CHANNELS];

  logic        any_fault;
  logic [31:0] gap, win;
  logic        ch_chg;
  logic [1:0]  new_code;

  always_comb begin
    any_fault = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (fcode_r[i] != FC_NONE) any_fault = 1'b1;
    end
  end

  // visited channel's differences
  assign gap = now_r - last_r[cnt_r];
  assign win = now_r - wstart_r[cnt_r];

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    acc_nxt         = acc_r;
    now_nxt         = now_r;
    since_start_nxt = since_start_r;
    strobe_nxt      = 1'b0;
    chg_nxt         = chg_r;
    active_nxt      = active_r;
    mon_since_nxt   = mon_since_r;
    fcode_nxt       = fcode_r;
    has_frm_nxt     = has_frm_r;
    last_nxt        = last_r;
    wstart_nxt      = wstart_r;
    fcount_nxt      = fcount_r;
    cmd_pop         = 1'b0;
    ch_chg          = 1'b0;
    new_code        = fcode_r[cnt_r];

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            OP_FRAME: begin
              strobe_nxt = 1'b1;
              chg_nxt    = 1'b0;
              if (active_r && cmd.ch_ok) begin
                last_nxt[cmd.ch]    = cmd.time_ms;
                has_frm_nxt[cmd.ch] = 1'b1;
                if (fcount_r[cmd.ch] != 16'hFFFF) begin
                  fcount_nxt[cmd.ch] = fcount_r[cmd.ch] + 16'd1;
                end
                if (fcode_r[cmd.ch] == FC_INTERRUPTED) begin
                  fcode_nxt[cmd.ch] = FC_NONE;
                  chg_nxt           = 1'b1;
                end
              end
            end
            OP_CHECK: begin
              if (active_r) begin
                state_nxt       = S_CHECK;
                cnt_nxt         = '0;
                acc_nxt         = 1'b0;
                now_nxt         = cmd.time_ms;
                since_start_nxt = (mon_since_r != '0) ? cmd.time_ms - mon_since_r : '0;
              end else begin
                strobe_nxt = 1'b1;
                chg_nxt    = 1'b0;
              end
            end
            OP_START, OP_STOP: begin
              for (int i = 0; i < CHANNELS; i++) begin
                fcode_nxt[i]   = FC_NONE;
                has_frm_nxt[i] = 1'b0;
                last_nxt[i]    = '0;
                wstart_nxt[i]  = '0;
                fcount_nxt[i]  = '0;
              end
              strobe_nxt = 1'b1;
              if (cmd.kind == OP_START) begin
                chg_nxt       = any_fault;
                mon_since_nxt = cmd.time_ms;
                active_nxt    = 1'b1;
              end else begin
                chg_nxt       = 1'b1;
                mon_since_nxt = '0;
                active_nxt    = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (!has_frm_r[cnt_r]) begin
          if (since_start_r > {16'd0, timeout_r}) new_code = FC_INTERRUPTED;
        end else if (fcode_r[cnt_r] != FC_INTERRUPTED) begin
          if (gap > {16'd0, timeout_r}) begin
            new_code = FC_INTERRUPTED;
          end else if (wstart_r[cnt_r] == '0) begin
            // window unset: open it now
            wstart_nxt[cnt_r] = now_r;
            if (fcount_r[cnt_r] == '0) fcount_nxt[cnt_r] = 16'd1;
          end else if (win >= {16'd0, window_r}) begin
            if (fcount_r[cnt_r] < min_frms_r) begin
              new_code = FC_LOW_RATE;
            end else if (fcode_r[cnt_r] == FC_LOW_RATE) begin
              new_code = FC_NONE;
            end
            wstart_nxt[cnt_r] = now_r;
            fcount_nxt[cnt_r] = '0;
          end
        end
        fcode_nxt[cnt_r] = new_code;
        ch_chg           = (new_code != fcode_r[cnt_r]);
        acc_nxt          = acc_r | ch_chg;
        if (cnt_r == CH_IDX_W'(CHANNELS - 1)) begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          chg_nxt    = acc_r | ch_chg;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_data.fault_codes = '0;
    for (int i = 0; i < SHOWN_CH; i++) begin
      out_data.fault_codes[2*i +: 2] = fcode_r[i];
    end
    out_data.changed = chg_r;
  end
  assign out_strobe = strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RST;
      window_r   <= WINDOW_RST;
      min_frms_r <= MIN_FRMS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT:  timeout_r  <= cfg_data;
        REG_WINDOW:   window_r   <= cfg_data;
        REG_MIN_FRMS: min_frms_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      acc_r       <= 1'b0;
      strobe_r    <= 1'b0;
      chg_r       <= 1'b0;
      active_r    <= 1'b0;
      mon_since_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        fcode_r[i]   <= FC_NONE;
        has_frm_r[i] <= 1'b0;
        last_r[i]    <= '0;
        wstart_r[i]  <= '0;
        fcount_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
      strobe_r    <= strobe_nxt;
      chg_r       <= chg_nxt;
      active_r    <= active_nxt;
      mon_since_r <= mon_since_nxt;
      fcode_r     <= fcode_nxt;
      has_frm_r   <= has_frm_nxt;
      last_r      <= last_nxt;
      wstart_r    <= wstart_nxt;
      fcount_r    <= fcount_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r         <= now_nxt;
    since_start_r <= since_start_nxt;
  end

endmodule

### src/camera_stream_fault_monitor.sv
// camera_stream_fault_monitor: per-channel video stream watchdog, top level.
// Instantiates csfm_front and csfm_back; depends on csfm_pkg.
//
//   channel | ports                              | beat taken when
//   --------+------------------------------------+-----------------------------
//   input   | start, busy, in_data               | start high, busy low
//   result  | out_strobe, out_data               | out_strobe high (one cycle)
//   config  | cfg_we, cfg_index, cfg_data        | cfg_we high
//
// Order: a taken beat is registered in the queue before the back end sees it. A frame,
//   start or stop beat is executed as the back end pops it; a check on an armed
//   monitor is dispatched first, then visits one channel per cycle.
//   The strobe is registered: it rises the cycle after the last back-end cycle.
// Stalls: a two-beat queue sits between front and back; busy rises when it is full.
//   The receiver cannot stall: each result is shown for exactly one cycle.
// Reset: synchronous, active low; clears queue, monitor and all channel state,
//   and loads the register defaults.
module camera_stream_fault_monitor (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  csfm_pkg::in_t  in_data,
  output logic           out_strobe,
  output csfm_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import csfm_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // front: accept and classify beats, queue them
  csfm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // back: state update, channel visits, result register
  csfm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

### tb/camera_stream_fault_monitor_test.sv
// camera_stream_fault_monitor_test: self-checking bench for the stream watchdog.
// Needs csfm_pkg and camera_stream_fault_monitor from src; reads no files.
`timescale 1ns / 1ps

module camera_stream_fault_monitor_test;
  import csfm_pkg::*;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_data;
  logic        out_strobe;
  out_t        out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  camera_stream_fault_monitor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop well past the slowest legal run (long idle gaps before every beat).
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Watchdog predictor: own copy of the registers and per-channel state.
  // Only the sampling block below writes these.
  // ---------------------------------------------------------------------------
  logic [15:0] timeout_r;
  logic [15:0] window_r;
  logic [15:0] min_frames_r;
  logic        armed_m;
  logic [31:0] armed_since;
  logic [1:0]  ch_code   [CHANNELS];
  logic        ch_seen   [CHANNELS];
  logic [31:0] ch_last   [CHANNELS];
  logic [31:0] ch_win    [CHANNELS];
  logic [15:0] ch_frames [CHANNELS];

  function automatic void wipe_channels();
    for (int c = 0; c < CHANNELS; c++) begin
      ch_code[c]   = FC_NONE;
      ch_seen[c]   = 1'b0;
      ch_last[c]   = '0;
      ch_win[c]    = '0;
      ch_frames[c] = '0;
    end
    armed_since = '0;
  endfunction

  // One channel's share of a periodic check; returns 1 when its code moved.
  function automatic bit visit_channel(int c, logic [31:0] now, logic [31:0] since);
    logic [1:0]  was;
    logic [31:0] gap;
    was = ch_code[c];
    if (!ch_seen[c]) begin
      // never had a frame: only the time since arming counts
      if (since > {16'd0, timeout_r}) ch_code[c] = FC_INTERRUPTED;
      return ch_code[c] != was;
    end
    if (was == FC_INTERRUPTED) return 1'b0;   // only a frame, start or stop clears it, never a check
    gap = now - ch_last[c];
    if (gap > {16'd0, timeout_r}) begin
      ch_code[c] = FC_INTERRUPTED;
      return 1'b1;
    end
    if (ch_win[c] == '0) begin
      // window unset; opening it at time zero leaves it unset again
      ch_win[c] = now;
      if (ch_frames[c] == '0) ch_frames[c] = 16'd1;
      return 1'b0;
    end
    if (now - ch_win[c] < {16'd0, window_r}) return 1'b0;
    if (ch_frames[c] < min_frames_r) ch_code[c] = FC_LOW_RATE;
    else if (was == FC_LOW_RATE) ch_code[c] = FC_NONE;
    ch_win[c]    = now;
    ch_frames[c] = '0;
    return ch_code[c] != was;
  endfunction

  // Applies one accepted beat to the predictor and returns the report it causes.
  function automatic out_t advance_watchdog(in_t beat);
    out_t        rpt;
    bit          moved;
    logic [31:0] since;
    int          c;
    moved = 1'b0;
    case (beat.operation)
      OP_FRAME: begin
        c = beat.channel;
        if (armed_m && c < CHANNELS) begin
          ch_last[c] = beat.time_ms;
          ch_seen[c] = 1'b1;
          if (ch_frames[c] != 16'hFFFF) ch_frames[c] = ch_frames[c] + 16'd1;
          if (ch_code[c] == FC_INTERRUPTED) begin
            ch_code[c] = FC_NONE;
            moved      = 1'b1;
          end
        end
      end
      OP_CHECK: begin
        if (armed_m) begin
          since = (armed_since != '0) ? beat.time_ms - armed_since : '0;
          for (int k = 0; k < CHANNELS; k++)
            if (visit_channel(k, beat.time_ms, since)) moved = 1'b1;
        end
      end
      OP_START: begin
        for (int k = 0; k < CHANNELS; k++)
          if (ch_code[k] != FC_NONE) moved = 1'b1;
        wipe_channels();
        armed_since = beat.time_ms;
        armed_m     = 1'b1;
      end
      default: begin   // stop: clears even when not armed, always flags a change
        wipe_channels();
        armed_m = 1'b0;
        moved   = 1'b1;
      end
    endcase
    rpt.fault_codes = '0;
    for (int k = 0; k < CHANNELS && k < 4; k++) rpt.fault_codes[2*k +: 2] = ch_code[k];
    rpt.changed = moved;
    return rpt;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard. Reports still owed, oldest first; each driven beat carries an
  // optional hand-typed expectation that overrides the predictor's.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    bit   known;
    out_t want;
  } hint_t;

  out_t  owed_reports [$];
  hint_t beat_hints   [$];
  int    fail_count;
  out_t  model_rpt;
  out_t  owed_rpt;
  hint_t hint_now;

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (fail_count < 50)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Everything is sampled at the rising edge, before the edge's own updates land.
  always @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    = TIMEOUT_RST;
      window_r     = WINDOW_RST;
      min_frames_r = MIN_FRMS_RST;
      armed_m      = 1'b0;
      wipe_channels();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMEOUT:  timeout_r    = cfg_data;
          REG_WINDOW:   window_r     = cfg_data;
          REG_MIN_FRMS: min_frames_r = cfg_data;
          default: ;
        endcase
      end
      if (out_strobe) begin
        if (owed_reports.size() == 0) begin
          flag_mismatch("unexpected report", out_data, '0);
        end else begin
          owed_rpt = owed_reports.pop_front();
          if (out_data.fault_codes !== owed_rpt.fault_codes)
            flag_mismatch("fault_codes", out_data.fault_codes, owed_rpt.fault_codes);
          if (out_data.changed !== owed_rpt.changed)
            flag_mismatch("changed", out_data.changed, owed_rpt.changed);
        end
      end
      if (start && !busy) begin
        hint_now  = beat_hints.pop_front();
        model_rpt = advance_watchdog(in_data);   // state moves on either way
        owed_reports.push_back(hint_now.known ? hint_now.want : model_rpt);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver. Inputs change only by nonblocking assignment at rising edges;
  // `driving` mirrors start so it is never lowered and raised in one step.
  // ---------------------------------------------------------------------------
  bit driving;
  bit gen_armed;   // stimulus side's view of arming, for counting useful beats

  function automatic int idle_gap(int mode);
    int pct;
    int g;
    pct = (mode == 1) ? 88 : (mode == 2) ? 11 : 0;
    g   = 0;
    while (g < 60 && $urandom_range(0, 99) < pct) g++;
    return g;
  endfunction

  task automatic send_beat(logic [1:0] op, logic [1:0] ch, logic [31:0] at_ms, int gap,
                           bit known = 1'b0, out_t want = '0);
    in_t beat;
    beat.operation = op;
    beat.channel   = ch;
    beat.time_ms   = at_ms;
    if (gap > 0) begin
      if (driving) start <= 1'b0;
      driving = 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat_hints.push_back('{known: known, want: want});
    start   <= 1'b1;
    in_data <= beat;
    driving  = 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic stop_driving();
    if (driving) start <= 1'b0;
    driving = 1'b0;
  endtask

  // Every beat yields one report, so an empty scoreboard means the block is idle.
  task automatic wait_idle();
    stop_driving();
    do @(posedge clk); while (owed_reports.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows: expectation typed in where it is obvious by eye, otherwise
  // left to the predictor. All under the reset register values.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  ch;
    logic [31:0] at_ms;
    bit          known;
    logic [7:0]  codes;
    bit          chg;
  } probe_t;

  localparam int N_PROBES = 23;
  probe_t probe_rows [N_PROBES] = '{
    '{OP_CHECK, 2'd0, 32'd100,        1'b1, 8'h00, 1'b0},  // check while disarmed
    '{OP_FRAME, 2'd3, 32'd200,        1'b1, 8'h00, 1'b0},  // frame while disarmed
    '{OP_STOP,  2'd0, 32'd0,          1'b1, 8'h00, 1'b1},  // stop when not armed
    '{OP_START, 2'd1, 32'd0,          1'b1, 8'h00, 1'b0},  // arm at time zero
    '{OP_CHECK, 2'd2, 32'd50000,      1'b1, 8'h00, 1'b0},  // since-start stays zero
    '{OP_START, 2'd0, 32'd1000,       1'b1, 8'h00, 1'b0},  // rearm while armed
    '{OP_CHECK, 2'd0, 32'd3001,       1'b1, 8'h55, 1'b1},  // all channels time out
    '{OP_CHECK, 2'd0, 32'd3002,       1'b0, 8'h00, 1'b0},
    '{OP_FRAME, 2'd0, 32'd3002,       1'b1, 8'h54, 1'b1},  // frame clears interruption
    '{OP_FRAME, 2'd0, 32'd3003,       1'b0, 8'h00, 1'b0},
    '{OP_CHECK, 2'd3, 32'd3003,       1'b0, 8'h00, 1'b0},  // window opens
    '{OP_CHECK, 2'd0, 32'd4003,       1'b0, 8'h00, 1'b0},  // window closes, low rate
    '{OP_FRAME, 2'd1, 32'd4004,       1'b0, 8'h00, 1'b0},
    '{OP_FRAME, 2'd3, 32'hFFFF_FFFF,  1'b0, 8'h00, 1'b0},
    '{OP_CHECK, 2'd0, 32'd4500,       1'b0, 8'h00, 1'b0},  // gap across the wrap
    '{OP_START, 2'd2, 32'hFFFF_FFFF,  1'b1, 8'h00, 1'b1},  // rearm with faults set
    '{OP_FRAME, 2'd0, 32'hFFFF_FFFF,  1'b0, 8'h00, 1'b0},
    '{OP_CHECK, 2'd0, 32'd0,          1'b0, 8'h00, 1'b0},  // window opened at zero
    '{OP_CHECK, 2'd0, 32'd5,          1'b0, 8'h00, 1'b0},  // ... reopens here
    '{OP_CHECK, 2'd0, 32'd1005,       1'b0, 8'h00, 1'b0},
    '{OP_FRAME, 2'd2, 32'd1006,       1'b0, 8'h00, 1'b0},
    '{OP_STOP,  2'd3, 32'hFFFF_FFFF,  1'b1, 8'h00, 1'b1},
    '{OP_FRAME, 2'd0, 32'd7,          1'b1, 8'h00, 1'b0}   // ignored after stop
  };

  // ---------------------------------------------------------------------------
  // Random sequences: mostly arm, then frames and checks on a rising clock of
  // milliseconds, with some channels left dead; a little noise mixed in.
  // ---------------------------------------------------------------------------
  task automatic run_sequence(int mode, output int useful);
    logic [31:0] now;
    logic [1:0]  op;
    logic [1:0]  ch;
    logic [3:0]  live;
    int          span;
    int          n;
    int          roll;
    useful = 0;
    case ($urandom_range(0, 9))
      0:       now = '0;
      1:       now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      default: now = $urandom;
    endcase
    case ($urandom_range(0, 3))
      0:       span = 1 + window_r / 16;
      1:       span = 1 + window_r / 4;
      2:       span = 1 + timeout_r / 2;
      default: span = 1 + timeout_r * 2;
    endcase
    live = ($urandom_range(0, 1) != 0) ? 4'hF : 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) != 0) begin
      send_beat(OP_START, 2'($urandom_range(0, 3)), now, idle_gap(mode));
      gen_armed = 1'b1;
      useful++;
    end
    n = $urandom_range(4, 40);
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) now = $urandom;
      else          now = now + $urandom_range(0, span);
      roll = $urandom_range(0, 99);
      ch   = 2'($urandom_range(0, 3));
      if (roll < 60)      op = live[ch] ? OP_FRAME : OP_CHECK;
      else if (roll < 94) op = OP_CHECK;
      else if (roll < 97) op = OP_START;
      else                op = OP_STOP;
      send_beat(op, ch, now, idle_gap(mode));
      if (gen_armed || op == OP_START || op == OP_STOP) useful++;
      if (op == OP_START) gen_armed = 1'b1;
      if (op == OP_STOP)  gen_armed = 1'b0;
    end
    if ($urandom_range(0, 3) == 0) begin
      send_beat(OP_STOP, 2'($urandom_range(0, 3)), now, idle_gap(mode));
      gen_armed = 1'b0;
      useful++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  localparam int N_PHASES     = 7;
  localparam int PHASE_BEATS  = 230;

  initial begin
    logic [15:0] ph_timeout [N_PHASES];
    logic [15:0] ph_window  [N_PHASES];
    logic [15:0] ph_min     [N_PHASES];
    int          got;
    int          counted;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_TIMEOUT;
    cfg_data   = '0;
    driving    = 1'b0;
    gen_armed  = 1'b0;
    fail_count = 0;

    // settings per phase: reset values, both extremes, ones, two random sets, then a fixed set
    ph_timeout = '{TIMEOUT_RST,  16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd300};
    ph_window  = '{WINDOW_RST,   16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd100};
    ph_min     = '{MIN_FRMS_RST, 16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd3};
    ph_timeout[4] = 16'($urandom_range(0, 65535));
    ph_window[4]  = 16'($urandom_range(0, 65535));
    ph_min[4]     = 16'($urandom_range(0, 65535));
    ph_timeout[5] = 16'($urandom_range(1, 3000));
    ph_window[5]  = 16'($urandom_range(1, 1500));
    ph_min[5]     = 16'($urandom_range(0, 20));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows, back to back, under the reset register values
    for (int r = 0; r < N_PROBES; r++)
      send_beat(probe_rows[r].op, probe_rows[r].ch, probe_rows[r].at_ms, 0,
                probe_rows[r].known, '{fault_codes: probe_rows[r].codes,
                                       changed: probe_rows[r].chg});
    wait_idle();

    // random phases; idling mode rotates: none, sender mostly idle, sender lightly idle
    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(REG_TIMEOUT,  ph_timeout[p]);
      write_reg(REG_WINDOW,   ph_window[p]);
      write_reg(REG_MIN_FRMS, ph_min[p]);
      counted = 0;
      while (counted < PHASE_BEATS) begin
        run_sequence(p % 3, got);
        counted += got;
      end
      wait_idle();
    end

    // let any stray report show up before judging
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
